// ===== rtl/rotary_stop_at_angle_speed_profile_defines.svh =====
// Assertion macros for the checker file of the speed profile block.
`ifndef ROTARY_STOP_AT_ANGLE_SPEED_PROFILE_DEFINES_SVH
`define ROTARY_STOP_AT_ANGLE_SPEED_PROFILE_DEFINES_SVH

// Concurrent assertion on a given clock with an active-low reset disable.
`define RSASP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// The same assertion on the block's own clock and reset.
`define RSASP_ASSERT_CLK(lbl, prop, msg) \
  `RSASP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/rsasp_pkg.sv =====
// Package with types, constants and codes of the rotary speed profile block.
package rsasp_pkg;

  localparam int unsigned SPEED_W = 20;
  localparam int unsigned TS_W    = 16;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned SQ_W    = 2 * SPEED_W;
  localparam int unsigned DVS_W   = SPEED_W + 1;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned CNT_W   = $clog2(Q_W);
  localparam int unsigned PATH_W  = 18;
  localparam int unsigned ERR_W   = 18;

  localparam logic [SPEED_W-1:0] SPEED_MAX      = '1;
  localparam logic [PATH_W-1:0]  FULL_TURN      = 18'd46080;
  localparam logic [PATH_W-1:0]  TWO_TURNS      = 18'd92160;
  localparam logic [PATH_W-1:0]  THREE_TURNS    = 18'd138240;
  localparam logic [ERR_W-1:0]   SPEEDUP_MARGIN = 18'd1280;
  localparam logic [ERR_W-1:0]   STOP_TOL       = 18'd38;
  localparam logic [SPEED_W-1:0] SNAP_SPEED     = 20'd128;
  localparam logic [35:0]        ROUND_HALF     = 36'd32768;

  localparam logic [TS_W-1:0]    TIME_STEP_RST  = 16'd655;
  localparam logic [SPEED_W-1:0] ACCEL_RST      = 20'd12800;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 20'd23040;
  localparam logic [SPEED_W-1:0] APPROACH_RST   = 20'd2560;

  typedef enum logic [1:0] {
    ACT_ACCEL = 2'd0,
    ACT_BRAKE = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    BR_SPEED_UP = 2'd0,
    BR_BRAKE    = 2'd1,
    BR_CREEP    = 2'd2,
    BR_FINAL    = 2'd3
  } branch_e;

  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_ACCEL     = 2'd1,
    CFG_MAX_SPEED = 2'd2,
    CFG_APPROACH  = 2'd3
  } cfg_index_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_D  = 6'b000010,
    ST_MUL_SQ = 6'b000100,
    ST_DIV_ST = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DECIDE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [ANG_W-1:0] current_angle;
    logic [ANG_W-1:0] target_angle;
    logic             clockwise;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] new_speed;
    logic [1:0]         branch;
  } out_t;

endpackage

// ===== rtl/rotary_stop_at_angle_speed_profile.sv =====
// Speed profile for a rotating axis with accelerate, brake and stop-at-angle moves.
// An input transaction is taken only in the idle state; the 17-step divider for the
// braking distance runs before the result, which waits for the output to be free.
// Configuration writes are taken in any cycle.
// Reset loads the register defaults and sets the held speed to zero.
module rotary_stop_at_angle_speed_profile import rsasp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [SPEED_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  state_e             state_q;
  state_e             state_d;
  logic [TS_W-1:0]    time_step_q;
  logic [SPEED_W-1:0] accel_q;
  logic [SPEED_W-1:0] max_speed_q;
  logic [SPEED_W-1:0] approach_q;
  logic [SPEED_W-1:0] speed_q;
  logic [SPEED_W-1:0] speed_d;
  logic [SPEED_W-1:0] d_q;
  logic [ANG_W-1:0]   path_q;
  in_t                item_q;
  logic               out_valid_q;
  out_t               out_q;
  branch_e            branch_d;

  logic [SPEED_W-1:0] mul_a;
  logic [SPEED_W-1:0] mul_b;
  logic [SQ_W-1:0]    mul_p;
  logic [35:0]        rounded;
  logic [DVS_W-1:0]   divisor;
  logic               div_start;
  logic               div_done;
  logic [Q_W-1:0]     stop_dist;
  logic [PATH_W-1:0]  biased;
  logic [PATH_W-1:0]  path_full;
  logic [ERR_W-1:0]   err_raw;
  logic [ERR_W-1:0]   err;
  logic [SPEED_W-1:0] braked;
  logic               commit;

  function automatic logic [SPEED_W-1:0] speed_up(input logic [SPEED_W-1:0] v,
                                                  input logic [SPEED_W-1:0] lim,
                                                  input logic [SPEED_W-1:0] d);
    logic [SPEED_W:0] sum;
    sum = {1'b0, v} + {1'b0, d};
    if (v >= lim) begin
      return lim;
    end else if (sum[SPEED_W]) begin
      return SPEED_MAX;
    end
    return sum[SPEED_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] slow_down(input logic [SPEED_W-1:0] v,
                                                   input logic [SPEED_W-1:0] d);
    return (v > d) ? (v - d) : '0;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mul_a = (state_q == ST_MUL_D) ? SPEED_W'(time_step_q) : speed_q;
  assign mul_b = (state_q == ST_MUL_D) ? accel_q : speed_q;

  rsasp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign rounded   = mul_p[35:0] + ROUND_HALF;
  assign divisor   = (accel_q == '0) ? DVS_W'(2) : {accel_q, 1'b0};
  assign div_start = (state_q == ST_DIV_ST);

  rsasp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (stop_dist)
  );

  always_comb begin
    if (item_q.clockwise) begin
      biased = TWO_TURNS + PATH_W'(item_q.target_angle) - PATH_W'(item_q.current_angle);
    end else begin
      biased = TWO_TURNS + PATH_W'(item_q.current_angle) - PATH_W'(item_q.target_angle);
    end
    if (biased >= THREE_TURNS) begin
      path_full = biased - THREE_TURNS;
    end else if (biased >= TWO_TURNS) begin
      path_full = biased - TWO_TURNS;
    end else if (biased >= FULL_TURN) begin
      path_full = biased - FULL_TURN;
    end else begin
      path_full = biased;
    end
  end

  assign err_raw = {2'b00, path_q} - {1'b0, stop_dist};
  assign err     = err_raw[ERR_W-1] ? (ERR_W'(0) - err_raw) : err_raw;
  assign braked  = slow_down(speed_q, d_q);

  always_comb begin
    speed_d  = speed_q;
    branch_d = BR_SPEED_UP;
    case (item_q.action)
      ACT_ACCEL: begin
        speed_d = speed_up(speed_q, max_speed_q, d_q);
      end
      ACT_BRAKE: begin
        speed_d  = braked;
        branch_d = BR_BRAKE;
      end
      ACT_STOP: begin
        if (err > SPEEDUP_MARGIN) begin
          speed_d = speed_up(speed_q, max_speed_q, d_q);
        end else if (speed_q > approach_q) begin
          speed_d  = braked;
          branch_d = BR_BRAKE;
        end else if (err > STOP_TOL) begin
          speed_d  = speed_up(speed_q, approach_q, d_q);
          branch_d = BR_CREEP;
        end else begin
          speed_d  = (braked < SNAP_SPEED) ? '0 : braked;
          branch_d = BR_FINAL;
        end
      end
      default: begin
        speed_d = speed_q;
      end
    endcase
  end

  assign commit = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_D;
        end
      end
      ST_MUL_D:  state_d = ST_MUL_SQ;
      ST_MUL_SQ: state_d = ST_DIV_ST;
      ST_DIV_ST: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      time_step_q <= TIME_STEP_RST;
      accel_q     <= ACCEL_RST;
      max_speed_q <= MAX_SPEED_RST;
      approach_q  <= APPROACH_RST;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
        speed_q     <= speed_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP: time_step_q <= cfg_data_i[TS_W-1:0];
          CFG_ACCEL:     accel_q     <= cfg_data_i;
          CFG_MAX_SPEED: max_speed_q <= cfg_data_i;
          CFG_APPROACH:  approach_q  <= cfg_data_i;
          default:       time_step_q <= time_step_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_MUL_SQ) begin
      d_q <= rounded[35:16];
    end
    if (state_q == ST_DIV_ST) begin
      path_q <= path_full[ANG_W-1:0];
    end
    if (commit) begin
      out_q.new_speed <= speed_d;
      out_q.branch    <= branch_d;
    end
  end

endmodule

// ===== rtl/rsasp_mul.sv =====
// Shared multiplier with a registered product.
module rsasp_mul import rsasp_pkg::*; (
  input  logic               clk_i,
  input  logic [SPEED_W-1:0] a_i,
  input  logic [SPEED_W-1:0] b_i,
  output logic [SQ_W-1:0]    p_o
);

  logic [SQ_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= SQ_W'(a_i) * SQ_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/rsasp_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated.
module rsasp_div import rsasp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [Q_W-1:0]   low_q;
  logic [Q_W-1:0]   quo_q;
  logic             ovf_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, low_q[Q_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      ovf_q <= dividend_i[SQ_W-1:Q_W] >= (SQ_W-Q_W)'(divisor_i);
      rem_q <= dividend_i[Q_W+DVS_W-1:Q_W];
      low_q <= dividend_i[Q_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], fits};
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(Q_W - 1));
  assign quot_o = ovf_q ? '1 : quo_q;

endmodule

// ===== rtl/rsasp_checker.sv =====
// Port-level checker for the speed profile block, bound to the top level.
`include "rotary_stop_at_angle_speed_profile_defines.svh"

module rsasp_checker import rsasp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  `RSASP_ASSERT_CLK(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o, "Input taken while busy.")
  `RSASP_ASSERT_CLK(a_result_after_work, $rose(out_valid_o) |-> $past(!in_ready_o), "Result without work.")
  `RSASP_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "Result dropped.")
  `RSASP_ASSERT_CLK(a_final_snap, out_valid_o && out_data_o.branch == BR_FINAL |-> out_data_o.new_speed == '0 || out_data_o.new_speed >= SNAP_SPEED, "Final speed not snapped.")

endmodule

bind rotary_stop_at_angle_speed_profile rsasp_checker u_rsasp_checker (.*);
